>>> src/porter_duff_pixel_blender_top_defines.svh
// assertion macros for the pixel blender
`ifndef PORTER_DUFF_PIXEL_BLENDER_TOP_DEFINES_SVH
`define PORTER_DUFF_PIXEL_BLENDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PDB_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pdb check failed");
`define PDB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdb check failed");
`define PDB_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("pdb check failed");
`else
`define PDB_ASSERT_ALWAYS(lbl, cond)
`define PDB_ASSERT_IMPLY(lbl, ante, cons)
`define PDB_ASSERT_DELAY(lbl, ante, dly, cons)
`endif

`endif

>>> src/pdb_pkg.sv
// shared types and constants of the pixel blender
package pdb_pkg;

  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 4;
  localparam int ALPHA_CH = 3;
  localparam int MODE_W  = 4;
  localparam int PROD_W  = 2 * CH_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int QUOT_W  = SUM_W - CH_W + 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // accept to strobe, in cycles
  localparam int LATENCY = 4;

  localparam logic [CH_W-1:0] ALPHA_MAX = 8'd255;
  localparam logic [CH_W-1:0] ALPHA_MIN = 8'd0;
  localparam logic [SUM_W-1:0] RND_BIAS = 18'd127;
  localparam logic [SUM_W:0] DIV_K = 19'd255;

  localparam logic [MODE_W-1:0] MODE_CLEAR    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SRC      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_DST      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SRC_OVER = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DST_OVER = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SRC_IN   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DST_IN   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SRC_OUT  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_DST_OUT  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SRC_ATOP = 4'd9;
  localparam logic [MODE_W-1:0] MODE_DST_ATOP = 4'd10;
  localparam logic [MODE_W-1:0] MODE_XOR      = 4'd11;
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_SRC_OVER;

  typedef enum logic [2:0] {
    OP_ZERO   = 3'd0,
    OP_PASS_P = 3'd1,
    OP_PASS_Q = 3'd2,
    OP_OVER   = 3'd3,
    OP_IN     = 3'd4,
    OP_OUT    = 3'd5,
    OP_ATOP   = 3'd6,
    OP_XOR    = 3'd7
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] q;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> src/pdb_front.sv
// front end: mode register, item classification and queue push
module pdb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pdb_pkg::PIX_W-1:0]    in_src_pixel,
  input  logic [pdb_pkg::PIX_W-1:0]    in_dst_pixel,
  input  logic                         cfg_we,
  input  logic [pdb_pkg::MODE_W-1:0]   cfg_wdata,
  input  pdb_pkg::q_stat_t             q_stat,
  output logic                         push,
  output pdb_pkg::item_t               push_item
);

  logic [pdb_pkg::MODE_W-1:0] mode_r;
  logic                       swap;
  logic [pdb_pkg::PIX_W-1:0]  p;
  logic [pdb_pkg::PIX_W-1:0]  q;
  logic [pdb_pkg::CH_W-1:0]   pa;
  logic [pdb_pkg::CH_W-1:0]   qa;
  pdb_pkg::op_t               op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pdb_pkg::MODE_RESET;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  always_comb begin
    swap = (mode_r inside {pdb_pkg::MODE_DST, pdb_pkg::MODE_DST_OVER, pdb_pkg::MODE_DST_IN,
                           pdb_pkg::MODE_DST_OUT, pdb_pkg::MODE_DST_ATOP});
    p  = swap ? in_dst_pixel : in_src_pixel;
    q  = swap ? in_src_pixel : in_dst_pixel;
    pa = p[pdb_pkg::PIX_W-1 -: pdb_pkg::CH_W];
    qa = q[pdb_pkg::PIX_W-1 -: pdb_pkg::CH_W];
    case (mode_r)
      pdb_pkg::MODE_SRC, pdb_pkg::MODE_DST: begin
        op = pdb_pkg::OP_PASS_P;
      end
      pdb_pkg::MODE_SRC_OVER, pdb_pkg::MODE_DST_OVER: begin
        if (pa == pdb_pkg::ALPHA_MIN) begin
          op = pdb_pkg::OP_PASS_Q;
        end else if (pa == pdb_pkg::ALPHA_MAX) begin
          op = pdb_pkg::OP_PASS_P;
        end else begin
          op = pdb_pkg::OP_OVER;
        end
      end
      pdb_pkg::MODE_SRC_IN, pdb_pkg::MODE_DST_IN: begin
        op = (pa == pdb_pkg::ALPHA_MIN || qa == pdb_pkg::ALPHA_MIN) ?
             pdb_pkg::OP_ZERO : pdb_pkg::OP_IN;
      end
      pdb_pkg::MODE_SRC_OUT, pdb_pkg::MODE_DST_OUT: begin
        op = (pa == pdb_pkg::ALPHA_MIN) ? pdb_pkg::OP_ZERO : pdb_pkg::OP_OUT;
      end
      pdb_pkg::MODE_SRC_ATOP, pdb_pkg::MODE_DST_ATOP: begin
        op = pdb_pkg::OP_ATOP;
      end
      pdb_pkg::MODE_XOR: begin
        op = pdb_pkg::OP_XOR;
      end
      default: begin
        op = pdb_pkg::OP_ZERO;
      end
    endcase
  end

  assign push         = start && !q_stat.full;
  assign push_item.op = op;
  assign push_item.p  = p;
  assign push_item.q  = q;

endmodule

>>> src/pdb_queue.sv
// short item queue between front and back end
module pdb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pdb_pkg::item_t    push_item,
  input  logic              pop,
  output pdb_pkg::item_t    pop_item,
  output pdb_pkg::q_stat_t  q_stat
);

  pdb_pkg::item_t                mem_r [pdb_pkg::QDEPTH];
  logic [pdb_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [pdb_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [pdb_pkg::QCNT_W-1:0]    count_r;
  logic [pdb_pkg::QPTR_W-1:0]    wr_ptr_nxt;
  logic [pdb_pkg::QPTR_W-1:0]    rd_ptr_nxt;
  logic [pdb_pkg::QCNT_W-1:0]    count_nxt;

  localparam logic [pdb_pkg::QPTR_W-1:0] PTR_LAST = pdb_pkg::QPTR_W'(pdb_pkg::QDEPTH - 1);
  localparam logic [pdb_pkg::QCNT_W-1:0] CNT_FULL = pdb_pkg::QCNT_W'(pdb_pkg::QDEPTH);
  localparam logic [pdb_pkg::QCNT_W-1:0] CNT_ONE  = pdb_pkg::QCNT_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_ONE;
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);

endmodule

>>> src/pdb_back.sv
// back end: multiply, sum and rounding pipeline
module pdb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pdb_pkg::q_stat_t           q_stat,
  input  pdb_pkg::item_t             pop_item,
  output logic                       pop,
  output logic                       out_valid,
  output logic [pdb_pkg::PIX_W-1:0]  out_blended_pixel
);

  localparam int CW = pdb_pkg::CH_W;
  localparam int NC = pdb_pkg::NUM_CH;

  // stage a: products
  logic                         va_r;
  pdb_pkg::op_t                 op_a_r;
  logic [pdb_pkg::PIX_W-1:0]    p_a_r;
  logic [pdb_pkg::PIX_W-1:0]    q_a_r;
  logic [pdb_pkg::PROD_W-1:0]   m1_a_r [NC];
  logic [pdb_pkg::PROD_W-1:0]   m2_a_r [NC];
  logic [pdb_pkg::PROD_W-1:0]   m1_a_nxt [NC];
  logic [pdb_pkg::PROD_W-1:0]   m2_a_nxt [NC];
  logic [CW-1:0]                mulx;
  logic [CW-1:0]                pinv;

  // stage b: sums
  logic                         vb_r;
  pdb_pkg::op_t                 op_b_r;
  logic [pdb_pkg::PIX_W-1:0]    pass_b_r;
  logic [pdb_pkg::SUM_W-1:0]    y_b_r [NC];
  logic [CW-1:0]                lin_b_r [NC];
  logic [pdb_pkg::PIX_W-1:0]    pass_b_nxt;
  logic [pdb_pkg::SUM_W-1:0]    y_b_nxt [NC];
  logic [CW-1:0]                lin_b_nxt [NC];

  // stage c: rounding and select
  logic                         out_valid_r;
  logic [pdb_pkg::PIX_W-1:0]    out_pixel_r;
  logic [pdb_pkg::PIX_W-1:0]    out_pixel_nxt;
  logic [pdb_pkg::SUM_W:0]      est_sum;
  logic [pdb_pkg::QUOT_W-1:0]   q0;
  logic [pdb_pkg::SUM_W:0]      rem;
  logic [pdb_pkg::QUOT_W-1:0]   quot;
  logic [CW-1:0]                rnd_ch;

  assign pop = !q_stat.empty;

  always_comb begin
    pinv = pdb_pkg::ALPHA_MAX - pop_item.p[pdb_pkg::PIX_W-1 -: CW];
    mulx = (pop_item.op == pdb_pkg::OP_IN || pop_item.op == pdb_pkg::OP_ATOP) ?
           pop_item.q[pdb_pkg::PIX_W-1 -: CW] :
           pdb_pkg::ALPHA_MAX - pop_item.q[pdb_pkg::PIX_W-1 -: CW];
    for (int i = 0; i < NC; i++) begin
      m1_a_nxt[i] = pdb_pkg::PROD_W'(pop_item.p[i*CW +: CW]) * pdb_pkg::PROD_W'(mulx);
      m2_a_nxt[i] = pdb_pkg::PROD_W'(pop_item.q[i*CW +: CW]) * pdb_pkg::PROD_W'(pinv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    op_a_r <= pop_item.op;
    p_a_r  <= pop_item.p;
    q_a_r  <= pop_item.q;
    for (int i = 0; i < NC; i++) begin
      m1_a_r[i] <= m1_a_nxt[i];
      m2_a_r[i] <= m2_a_nxt[i];
    end
  end

  always_comb begin
    case (op_a_r)
      pdb_pkg::OP_PASS_P: pass_b_nxt = p_a_r;
      pdb_pkg::OP_PASS_Q: pass_b_nxt = q_a_r;
      default:            pass_b_nxt = '0;
    endcase
    for (int i = 0; i < NC; i++) begin
      y_b_nxt[i] = pdb_pkg::SUM_W'(m1_a_r[i]) + pdb_pkg::SUM_W'(m2_a_r[i]) + pdb_pkg::RND_BIAS;
      if (op_a_r == pdb_pkg::OP_OVER) begin
        lin_b_nxt[i] = p_a_r[i*CW +: CW] + m2_a_r[i][pdb_pkg::PROD_W-1 -: CW];
      end else begin
        lin_b_nxt[i] = m1_a_r[i][pdb_pkg::PROD_W-1 -: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    op_b_r   <= op_a_r;
    pass_b_r <= pass_b_nxt;
    for (int i = 0; i < NC; i++) begin
      y_b_r[i]   <= y_b_nxt[i];
      lin_b_r[i] <= lin_b_nxt[i];
    end
  end

  // divide by 255: estimate from shifts, then one correction step
  always_comb begin
    out_pixel_nxt = pass_b_r;
    est_sum = '0;
    q0      = '0;
    rem     = '0;
    quot    = '0;
    rnd_ch  = '0;
    for (int i = 0; i < NC; i++) begin
      est_sum = {1'b0, y_b_r[i]} + {{(CW+1){1'b0}}, y_b_r[i][pdb_pkg::SUM_W-1:CW]};
      q0      = est_sum[pdb_pkg::SUM_W:CW];
      rem     = {1'b0, y_b_r[i]} - (({q0, {CW{1'b0}}}) - (pdb_pkg::SUM_W+1)'(q0));
      quot    = q0 + pdb_pkg::QUOT_W'(rem >= pdb_pkg::DIV_K);
      if (op_b_r == pdb_pkg::OP_ATOP && i == pdb_pkg::ALPHA_CH &&
          quot > pdb_pkg::QUOT_W'(pdb_pkg::ALPHA_MAX)) begin
        rnd_ch = pdb_pkg::ALPHA_MAX;
      end else begin
        rnd_ch = quot[CW-1:0];
      end
      case (op_b_r)
        pdb_pkg::OP_OVER, pdb_pkg::OP_IN, pdb_pkg::OP_OUT: begin
          out_pixel_nxt[i*CW +: CW] = lin_b_r[i];
        end
        pdb_pkg::OP_ATOP, pdb_pkg::OP_XOR: begin
          out_pixel_nxt[i*CW +: CW] = rnd_ch;
        end
        default: begin
          out_pixel_nxt[i*CW +: CW] = pass_b_r[i*CW +: CW];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_blended_pixel = out_pixel_r;

endmodule

>>> src/porter_duff_pixel_blender_top.sv
// top level of the porter-duff pixel blender
// Takes one source/destination pixel pair per clock and gives one blended pixel per clock.
// An item is taken when start is high and busy is low; its result is on
// out_blended_pixel with out_valid high for one cycle, once the item has passed the queue
// hop and the three-stage multiply, sum and divide-by-255 pipeline of the back end. The
// back end drains the two-entry queue every cycle and the result side never stalls, so
// busy stays low and items may follow each other in every cycle. The blend mode is
// written through cfg_we/cfg_wdata; the user must write it only while no item is in
// flight, which the block itself does not enforce. It resets to source-over.
`include "porter_duff_pixel_blender_top_defines.svh"

module porter_duff_pixel_blender_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pdb_pkg::PIX_W-1:0]    in_src_pixel,
  input  logic [pdb_pkg::PIX_W-1:0]    in_dst_pixel,
  input  logic                         cfg_we,
  input  logic [pdb_pkg::MODE_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output logic [pdb_pkg::PIX_W-1:0]    out_blended_pixel
);

  pdb_pkg::q_stat_t q_stat;
  pdb_pkg::item_t   push_item;
  pdb_pkg::item_t   pop_item;
  logic             push;
  logic             pop;

  pdb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_src_pixel (in_src_pixel),
    .in_dst_pixel (in_dst_pixel),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  pdb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  pdb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .pop_item          (pop_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_blended_pixel (out_blended_pixel)
  );

  assign busy = q_stat.full;

  // back end drains the queue every cycle, so it never fills
  `PDB_ASSERT_ALWAYS(a_never_full, !q_stat.full)
  `PDB_ASSERT_DELAY(a_accept_to_strobe, start && !busy, pdb_pkg::LATENCY, out_valid)
  `PDB_ASSERT_IMPLY(a_strobe_has_item, out_valid, $past(push, pdb_pkg::LATENCY))

endmodule

>>> tb/sv/tb_porter_duff_pixel_blender_top.sv
// self-checking testbench for the porter-duff pixel blender top level
`timescale 1ns / 100ps

class pixel_blend_checker;
  logic [pdb_pkg::MODE_W-1:0] mode;
  logic [pdb_pkg::PIX_W-1:0]  expected_pixels[$];
  int unsigned                n_noted;
  int unsigned                n_checked;
  int unsigned                n_errors;

  function new();
    mode      = pdb_pkg::MODE_RESET;
    n_noted   = 0;
    n_checked = 0;
    n_errors  = 0;
  endfunction

  function int unsigned round255(int unsigned x);
    return (2 * x + 255) / 510;
  endfunction

  // p is the upper pixel, q the lower one
  function logic [pdb_pkg::PIX_W-1:0] combine(pdb_pkg::op_t op,
                                              logic [pdb_pkg::PIX_W-1:0] p,
                                              logic [pdb_pkg::PIX_W-1:0] q);
    int unsigned pa, qa, pc, qc, v;
    int i;
    logic [pdb_pkg::PIX_W-1:0] r;
    pa = p[31:24];
    qa = q[31:24];
    r = '0;
    if (op == pdb_pkg::OP_OVER) begin
      if (pa == 0) return q;
      if (pa == 255) return p;
    end else if (op == pdb_pkg::OP_IN) begin
      if (pa == 0 || qa == 0) return '0;
    end else if (op == pdb_pkg::OP_OUT) begin
      if (pa == 0) return '0;
    end
    for (i = 0; i < pdb_pkg::NUM_CH; i++) begin
      pc = p[pdb_pkg::CH_W*i +: pdb_pkg::CH_W];
      qc = q[pdb_pkg::CH_W*i +: pdb_pkg::CH_W];
      case (op)
        pdb_pkg::OP_OVER: v = pc + ((qc * (255 - pa)) >> 8);
        pdb_pkg::OP_IN:   v = (pc * qa) >> 8;
        pdb_pkg::OP_OUT:  v = (pc * (255 - qa)) >> 8;
        pdb_pkg::OP_ATOP: begin
          v = round255(pc * qa + qc * (255 - pa));
          if (i == pdb_pkg::ALPHA_CH && v > 255) v = 255;
        end
        default: v = round255(pc * (255 - qa) + qc * (255 - pa));
      endcase
      r[pdb_pkg::CH_W*i +: pdb_pkg::CH_W] = v[pdb_pkg::CH_W-1:0];
    end
    return r;
  endfunction

  function logic [pdb_pkg::PIX_W-1:0] blend_pixel(logic [pdb_pkg::PIX_W-1:0] s,
                                                  logic [pdb_pkg::PIX_W-1:0] d);
    case (mode)
      pdb_pkg::MODE_SRC:      return s;
      pdb_pkg::MODE_DST:      return d;
      pdb_pkg::MODE_SRC_OVER: return combine(pdb_pkg::OP_OVER, s, d);
      pdb_pkg::MODE_DST_OVER: return combine(pdb_pkg::OP_OVER, d, s);
      pdb_pkg::MODE_SRC_IN:   return combine(pdb_pkg::OP_IN, s, d);
      pdb_pkg::MODE_DST_IN:   return combine(pdb_pkg::OP_IN, d, s);
      pdb_pkg::MODE_SRC_OUT:  return combine(pdb_pkg::OP_OUT, s, d);
      pdb_pkg::MODE_DST_OUT:  return combine(pdb_pkg::OP_OUT, d, s);
      pdb_pkg::MODE_SRC_ATOP: return combine(pdb_pkg::OP_ATOP, s, d);
      pdb_pkg::MODE_DST_ATOP: return combine(pdb_pkg::OP_ATOP, d, s);
      pdb_pkg::MODE_XOR:      return combine(pdb_pkg::OP_XOR, s, d);
      default:                return '0;
    endcase
  endfunction

  function void note_pair(logic [pdb_pkg::PIX_W-1:0] s, logic [pdb_pkg::PIX_W-1:0] d);
    expected_pixels.push_back(blend_pixel(s, d));
    n_noted++;
  endfunction

  function void check_pixel(logic [pdb_pkg::PIX_W-1:0] actual);
    logic [pdb_pkg::PIX_W-1:0] want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected blended_pixel %08h with no item pending", actual);
      n_errors++;
      return;
    end
    want = expected_pixels.pop_front();
    n_checked++;
    if (actual !== want) begin
      $error("blended_pixel mismatch: expected %08h actual %08h", want, actual);
      n_errors++;
    end
  endfunction

  function int pending();
    return expected_pixels.size();
  endfunction
endclass

module tb_porter_duff_pixel_blender_top;
  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [pdb_pkg::PIX_W-1:0]  in_src_pixel;
  logic [pdb_pkg::PIX_W-1:0]  in_dst_pixel;
  logic                       cfg_we;
  logic [pdb_pkg::MODE_W-1:0] cfg_wdata;
  logic                       out_valid;
  logic [pdb_pkg::PIX_W-1:0]  out_blended_pixel;

  pixel_blend_checker         chk;
  int unsigned                mode_writes;
  logic [pdb_pkg::PIX_W-1:0]  corner_src[8];
  logic [pdb_pkg::PIX_W-1:0]  corner_dst[8];

  porter_duff_pixel_blender_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_src_pixel      (in_src_pixel),
    .in_dst_pixel      (in_dst_pixel),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_blended_pixel (out_blended_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("FAIL porter_duff_pixel_blender_top");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) chk.note_pair(in_src_pixel, in_dst_pixel);
    if (rst_n && out_valid) chk.check_pixel(out_blended_pixel);
  end

  function automatic logic [pdb_pkg::PIX_W-1:0] random_pixel();
    logic [pdb_pkg::CH_W-1:0] a;
    logic [pdb_pkg::PIX_W-1:0] px;
    int sel;
    int i;
    sel = $urandom_range(0, 9);
    if (sel < 2) a = 8'd0;
    else if (sel < 4) a = 8'd255;
    else a = pdb_pkg::CH_W'($urandom_range(0, 255));
    px = $urandom;
    px[31:24] = a;
    if ($urandom_range(0, 9) < 7) begin
      for (i = 0; i < 3; i++) begin
        px[pdb_pkg::CH_W*i +: pdb_pkg::CH_W] = pdb_pkg::CH_W'($urandom_range(0, a));
      end
    end
    return px;
  endfunction

  // starts and ends at a falling edge
  task automatic send_pair(input logic [pdb_pkg::PIX_W-1:0] s,
                           input logic [pdb_pkg::PIX_W-1:0] d,
                           input bit idle_ok);
    while (idle_ok && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_src_pixel <= s;
    in_dst_pixel <= d;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic set_mode(input logic [pdb_pkg::MODE_W-1:0] m);
    start <= 1'b0;
    @(negedge clk);
    while (chk.pending() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    chk.mode = m;
    mode_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int m, k, p, n;
    logic [pdb_pkg::MODE_W-1:0] pm;
    chk          = new();
    mode_writes  = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_src_pixel = '0;
    in_dst_pixel = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;

    corner_src[0] = 32'h00ffffff; corner_dst[0] = 32'hff80c040;
    corner_src[1] = 32'hff102030; corner_dst[1] = 32'h80404040;
    corner_src[2] = 32'h80402010; corner_dst[2] = 32'h40302010;
    corner_src[3] = 32'h00ffffff; corner_dst[3] = 32'h00ffffff;
    corner_src[4] = 32'hffffffff; corner_dst[4] = 32'hffffffff;
    corner_src[5] = 32'h00000000; corner_dst[5] = 32'h00000000;
    corner_src[6] = 32'h10ff80ff; corner_dst[6] = 32'hc0a0b0c0;
    corner_src[7] = 32'hff000000; corner_dst[7] = 32'h00ffffff;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset mode first, then every code including the unused ones
    for (k = 0; k < 4; k++) send_pair(corner_src[k * 2], corner_dst[k * 2 + 1], 1'b1);
    for (m = 0; m < 16; m++) begin
      set_mode(m[pdb_pkg::MODE_W-1:0]);
      n = (m < 12) ? 2 : 1;
      for (k = 0; k < n; k++) send_pair(corner_src[(m * 2 + k) % 8],
                                        corner_dst[(m * 2 + k) % 8], 1'b1);
    end

    for (p = 0; p < 18; p++) begin
      pm = (p < 16) ? p[pdb_pkg::MODE_W-1:0] : pdb_pkg::MODE_W'($urandom_range(0, 15));
      set_mode(pm);
      for (k = 0; k < 50; k++) send_pair(random_pixel(), random_pixel(), !(p == 9 || p == 10));
    end

    start <= 1'b0;
    n = 0;
    while (chk.pending() != 0 && n < 1000) begin
      @(negedge clk);
      n++;
    end
    repeat (pdb_pkg::LATENCY + 4) @(negedge clk);
    if (chk.pending() != 0) begin
      $error("%0d blended pixels never arrived", chk.pending());
      chk.n_errors++;
    end

    $display("%0d pixel pairs blended under %0d mode writes covering all 16 mode codes",
             chk.n_noted, mode_writes);
    $display("%0d results compared, %0d errors", chk.n_checked, chk.n_errors);
    if (chk.n_errors == 0) begin
      $display("PASS porter_duff_pixel_blender_top");
    end else begin
      $display("FAIL porter_duff_pixel_blender_top");
    end
    $finish;
  end
endmodule
